@@ hdl/urb_pkg.sv @@
// ----------------------------------------------------------------------------
// urb_pkg
// Shared types and codes for the UART ring buffer pair: event kinds,
// result status codes, field widths and the controller command bundle.
// ----------------------------------------------------------------------------
package urb_pkg;

	localparam int QUEUE_DEPTH_DEF = 64;

	localparam int KIND_W   = 2;
	localparam int DATA_W   = 8;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 6;

	// event kinds
	localparam logic [KIND_W-1:0] KIND_RX_BYTE  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_TX_READY = 2'd1;
	localparam logic [KIND_W-1:0] KIND_HOST_RD  = 2'd2;
	localparam logic [KIND_W-1:0] KIND_HOST_WR  = 2'd3;

	// result status
	localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FRAMING = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
	localparam logic [STATUS_W-1:0] ST_IDLE    = 2'd3;

	typedef struct packed {
		logic capture;  // latch the incoming event
		logic execute;  // update queues, launch store reads
		logic load;     // fill the result register
	} urb_cmd_t;

endpackage

@@ hdl/urb_ctrl.sv @@
// ----------------------------------------------------------------------------
// urb_ctrl
// Sequencer for one event: capture, execute, load result, hold result
// until the receiver takes it.
// ----------------------------------------------------------------------------
module urb_ctrl import urb_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	output logic     res_valid,
	input  logic     res_stall,
	output urb_cmd_t cmd
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_LOAD = 2'd2;
	localparam logic [1:0] S_HOLD = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_nxt;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_nxt = S_EXEC;
				end
			end
			S_EXEC: begin
				state_nxt = S_LOAD;
			end
			S_LOAD: begin
				state_nxt = S_HOLD;
			end
			S_HOLD: begin
				if (!res_stall) begin
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign in_stall    = (state_q != S_IDLE);
	assign res_valid   = (state_q == S_HOLD);
	assign cmd.capture = in_valid && (state_q == S_IDLE);
	assign cmd.execute = (state_q == S_EXEC);
	assign cmd.load    = (state_q == S_LOAD);

endmodule

@@ hdl/urb_datapath.sv @@
// ----------------------------------------------------------------------------
// urb_datapath
// Receive and transmit ring buffers with their pointers, the transmit
// interrupt flag and the result register.
// ----------------------------------------------------------------------------
module urb_datapath import urb_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  urb_cmd_t            cmd,
	input  logic [KIND_W-1:0]   kind,
	input  logic [DATA_W-1:0]   data,
	input  logic                framing_error,
	output logic [DATA_W-1:0]   out_data,
	output logic                out_valid,
	output logic [STATUS_W-1:0] status,
	output logic [COUNT_W-1:0]  rx_count,
	output logic [COUNT_W-1:0]  tx_space,
	output logic                tx_irq_enable
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam logic [PTR_W-1:0] PTR_ONE = PTR_W'(1);

	// captured event
	logic [KIND_W-1:0]   kind_q;
	logic [DATA_W-1:0]   data_q;
	logic                ferr_q;

	// queue state
	logic [DATA_W-1:0]   rx_mem [QUEUE_DEPTH];
	logic [DATA_W-1:0]   tx_mem [QUEUE_DEPTH];
	logic [PTR_W-1:0]    rx_wr_q, rx_rd_q, tx_wr_q, tx_rd_q;
	logic                irq_q;

	// execute results
	logic [DATA_W-1:0]   rx_dout_q, tx_dout_q;
	logic [STATUS_W-1:0] st_q;
	logic                ovalid_q;

	// result register
	logic [DATA_W-1:0]   out_data_q;
	logic                out_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic [COUNT_W-1:0]  rx_count_q, tx_space_q;
	logic                irq_out_q;

	// decisions for the execute step
	logic [STATUS_W-1:0] st_nxt;
	logic                ovalid_nxt;
	logic                rx_push, rx_pop, tx_push, tx_pop, irq_clr;
	logic [PTR_W-1:0]    rx_used, tx_free;
	logic [PTR_W+COUNT_W-1:0] rx_used_ext, tx_free_ext;

	assign rx_used = rx_wr_q - rx_rd_q;
	assign tx_free = tx_rd_q - tx_wr_q - PTR_ONE;

	always_comb begin
		st_nxt     = ST_DONE;
		ovalid_nxt = 1'b0;
		rx_push    = 1'b0;
		rx_pop     = 1'b0;
		tx_push    = 1'b0;
		tx_pop     = 1'b0;
		irq_clr    = 1'b0;
		unique case (kind_q)
			KIND_RX_BYTE: begin
				if (ferr_q) begin
					st_nxt = ST_FRAMING;
				end else if (rx_rd_q == rx_wr_q + PTR_ONE) begin
					st_nxt = ST_FULL;
				end else begin
					rx_push = 1'b1;
				end
			end
			KIND_TX_READY: begin
				if (!irq_q) begin
					st_nxt = ST_IDLE;
				end else if (tx_rd_q == tx_wr_q) begin
					irq_clr = 1'b1;
					st_nxt  = ST_IDLE;
				end else begin
					tx_pop     = 1'b1;
					ovalid_nxt = 1'b1;
				end
			end
			KIND_HOST_RD: begin
				if (rx_used == '0) begin
					st_nxt = ST_IDLE;
				end else begin
					rx_pop     = 1'b1;
					ovalid_nxt = 1'b1;
				end
			end
			KIND_HOST_WR: begin
				if (tx_free == '0) begin
					st_nxt = ST_FULL;
				end else begin
					tx_push = 1'b1;
				end
			end
			default: begin
				st_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q <= kind;
			data_q <= data;
			ferr_q <= framing_error;
		end
	end

	// stores: one write and one registered read each
	always_ff @(posedge clk) begin
		if (cmd.execute && rx_push) begin
			rx_mem[rx_wr_q] <= data_q;
		end
		if (cmd.execute) begin
			rx_dout_q <= rx_mem[rx_rd_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.execute && tx_push) begin
			tx_mem[tx_wr_q] <= data_q;
		end
		if (cmd.execute) begin
			tx_dout_q <= tx_mem[tx_rd_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_wr_q <= '0;
			rx_rd_q <= '0;
			tx_wr_q <= '0;
			tx_rd_q <= '0;
			irq_q   <= 1'b0;
		end else if (cmd.execute) begin
			if (rx_push) rx_wr_q <= rx_wr_q + PTR_ONE;
			if (rx_pop)  rx_rd_q <= rx_rd_q + PTR_ONE;
			if (tx_push) tx_wr_q <= tx_wr_q + PTR_ONE;
			if (tx_pop)  tx_rd_q <= tx_rd_q + PTR_ONE;
			if (tx_push) begin
				irq_q <= 1'b1;
			end else if (irq_clr) begin
				irq_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.execute) begin
			st_q     <= st_nxt;
			ovalid_q <= ovalid_nxt;
		end
	end

	// counts are reported in six bits whatever the pointer width
	assign rx_used_ext = {{COUNT_W{1'b0}}, rx_used};
	assign tx_free_ext = {{COUNT_W{1'b0}}, tx_free};

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			if (!ovalid_q) begin
				out_data_q <= '0;
			end else if (kind_q == KIND_TX_READY) begin
				out_data_q <= tx_dout_q;
			end else begin
				out_data_q <= rx_dout_q;
			end
			out_valid_q <= ovalid_q;
			status_q    <= st_q;
			rx_count_q  <= rx_used_ext[COUNT_W-1:0];
			tx_space_q  <= tx_free_ext[COUNT_W-1:0];
			irq_out_q   <= irq_q;
		end
	end

	assign out_data      = out_data_q;
	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign rx_count      = rx_count_q;
	assign tx_space      = tx_space_q;
	assign tx_irq_enable = irq_out_q;

endmodule

@@ hdl/uart_ring_buffers_unit.sv @@
// ----------------------------------------------------------------------------
// uart_ring_buffers_unit
// Receive and transmit byte queues between a UART and a host.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one event: kind, data and
//   framing_error. Kinds: byte received, transmitter ready, host reads a
//   byte, host queues a byte. Each event gives exactly one result on the
//   output channel (res_valid / res_stall): the byte read or sent, its
//   valid flag, a status code, the receive count, the free transmit space
//   and the transmit interrupt flag.
//   Each queue holds QUEUE_DEPTH-1 bytes; one slot always stays empty.
//   The result is offered once the queue update with store read and then
//   the result load are done. The block takes one event at a time and
//   takes no new event until its result is taken; the registered read of
//   the byte stores is why the result load is a step of its own.
//   While the receiver stalls, the result holds and in_stall stays high.
//   Reset clears all pointers and the interrupt flag; queue contents are
//   not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module uart_ring_buffers_unit import urb_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [KIND_W-1:0]   kind,
	input  logic [DATA_W-1:0]   data,
	input  logic                framing_error,
	output logic                res_valid,
	input  logic                res_stall,
	output logic [DATA_W-1:0]   out_data,
	output logic                out_valid,
	output logic [STATUS_W-1:0] status,
	output logic [COUNT_W-1:0]  rx_count,
	output logic [COUNT_W-1:0]  tx_space,
	output logic                tx_irq_enable
);

	urb_cmd_t cmd;

	urb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.cmd       (cmd)
	);

	urb_datapath #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.kind          (kind),
		.data          (data),
		.framing_error (framing_error),
		.out_data      (out_data),
		.out_valid     (out_valid),
		.status        (status),
		.rx_count      (rx_count),
		.tx_space      (tx_space),
		.tx_irq_enable (tx_irq_enable)
	);

endmodule
